// File: rtl/srr_pkg.sv
package srr_pkg;

    // Defaults of the top-level parameters.
    localparam int WINDOW_SLOTS_DEF = 8;
    localparam int SEQ_BITS_DEF     = 16;
    localparam int MAX_PAYLOAD_DEF  = 1024;

    // Fixed field widths of the ports.
    localparam int SEQ_W   = 16;
    localparam int REF_W   = 32;
    localparam int LEN_W   = 11;
    localparam int KIND_W  = 2;
    localparam int BYTES_W = 32;

    // Result kinds as they appear on the kind port.
    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    // Source of a result that the controller asks the datapath to emit.
    typedef enum logic [1:0] {
        SRC_CUR_DELIVER  = 2'd0,
        SRC_ACK          = 2'd1,
        SRC_REJECT       = 2'd2,
        SRC_SLOT_DELIVER = 2'd3
    } emit_src_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        emit_src_t src;
        logic      advance;
        logic      store;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic is_exp;
        logic in_win;
        logic behind;
        logic slot1_full;
        logic out_free;
    } status_t;

endpackage

// File: rtl/srr_ctrl.sv
module srr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  srr_pkg::status_t status,
    output srr_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ACK_EXP,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd         = '0;
        cmd.src     = srr_pkg::SRC_ACK;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.is_exp)
                    begin
                        cmd.src    = srr_pkg::SRC_CUR_DELIVER;
                        state_next = ST_ACK_EXP;
                    end
                    else if (status.in_win)
                    begin
                        cmd.src    = srr_pkg::SRC_ACK;
                        cmd.store  = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (status.behind)
                    begin
                        cmd.src    = srr_pkg::SRC_ACK;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.src    = srr_pkg::SRC_REJECT;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ACK_EXP:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.src     = srr_pkg::SRC_ACK;
                    cmd.advance = 1'b1;
                    cmd.last    = !status.slot1_full;
                    state_next  = status.slot1_full ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.src     = srr_pkg::SRC_SLOT_DELIVER;
                    cmd.advance = 1'b1;
                    cmd.last    = !status.slot1_full;
                    state_next  = status.slot1_full ? ST_DRAIN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The final result of a packet always hands control back to the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("last result did not return the controller to idle");

    // A result is only produced when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted while output register is occupied");

    // A packet is captured only at an edge where the input channel accepts it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (in_valid && !in_stall))
        else $error("packet captured without an input handshake");

endmodule

// File: rtl/srr_dp.sv
module srr_dp #(
    parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
    parameter int MAX_PAYLOAD  = srr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srr_pkg::BYTES_W-1:0]   cfg_data,
    input  logic [srr_pkg::SEQ_W-1:0]     packet_seq,
    input  logic [srr_pkg::REF_W-1:0]     payload_ref,
    input  logic [srr_pkg::LEN_W-1:0]     payload_len,
    input  srr_pkg::cmd_t                 cmd,
    output srr_pkg::status_t              status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [srr_pkg::KIND_W-1:0]    kind,
    output logic [srr_pkg::SEQ_W-1:0]     out_seq,
    output logic [srr_pkg::REF_W-1:0]     out_ref,
    output logic [srr_pkg::LEN_W-1:0]     out_len,
    output logic [srr_pkg::BYTES_W-1:0]   bytes_so_far,
    output logic                          transfer_done,
    output logic                          last
);

    localparam int SLOT_IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int LEN_W   = srr_pkg::LEN_W;
    localparam int REF_W   = srr_pkg::REF_W;
    localparam int BYTES_W = srr_pkg::BYTES_W;

    // Configuration and running state.
    logic [BYTES_W-1:0]      expected_total_reg;
    logic [BYTES_W-1:0]      delivered_reg;
    logic [SEQ_BITS-1:0]     next_exp_reg;
    logic [WINDOW_SLOTS-1:0] slot_full_reg;
    logic [REF_W-1:0]        slot_ref_reg [WINDOW_SLOTS];
    logic [LEN_W-1:0]        slot_len_reg [WINDOW_SLOTS];

    // Current packet.
    logic [SEQ_BITS-1:0]     seq_reg;
    logic [SEQ_BITS-1:0]     off_reg;
    logic [REF_W-1:0]        ref_reg;
    logic [LEN_W-1:0]        len_reg;

    // Output register.
    logic                    out_valid_reg;
    srr_pkg::kind_t          kind_reg;
    logic [SEQ_BITS-1:0]     out_seq_reg;
    logic [REF_W-1:0]        out_ref_reg;
    logic [LEN_W-1:0]        out_len_reg;
    logic [BYTES_W-1:0]      bytes_reg;
    logic                    done_reg;
    logic                    last_reg;

    logic [SEQ_BITS-1:0]     seq_in;
    logic [LEN_W-1:0]        len_clamped;
    logic [SEQ_BITS-1:0]     off_neg;
    logic [SLOT_IW-1:0]      off_idx;
    logic [WINDOW_SLOTS:0]   full_ext;
    logic                    store_en;

    srr_pkg::kind_t          kind_next;
    logic [SEQ_BITS-1:0]     seq_next;
    logic [REF_W-1:0]        ref_next;
    logic [LEN_W-1:0]        len_next;
    logic [BYTES_W:0]        sum_next;
    logic [BYTES_W-1:0]      bytes_next;

    assign seq_in      = SEQ_BITS'(packet_seq);
    assign len_clamped = (32'(payload_len) > 32'(MAX_PAYLOAD)) ?
                         LEN_W'(MAX_PAYLOAD) : payload_len;

    // Window classification from the registered offset.
    assign off_neg  = SEQ_BITS'(0) - off_reg;
    assign off_idx  = off_reg[SLOT_IW-1:0];
    assign full_ext = {1'b0, slot_full_reg};
    assign store_en = cmd.store && !slot_full_reg[off_idx];

    assign status.is_exp     = (off_reg == '0);
    assign status.in_win     = (off_reg < SEQ_BITS'(WINDOW_SLOTS));
    assign status.behind     = (off_neg <= SEQ_BITS'(WINDOW_SLOTS));
    assign status.slot1_full = full_ext[1];
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        kind_next = srr_pkg::KIND_ACK;
        seq_next  = seq_reg;
        ref_next  = '0;
        len_next  = '0;
        case (cmd.src)
            srr_pkg::SRC_CUR_DELIVER:
            begin
                kind_next = srr_pkg::KIND_DELIVER;
                ref_next  = ref_reg;
                len_next  = len_reg;
            end
            srr_pkg::SRC_SLOT_DELIVER:
            begin
                kind_next = srr_pkg::KIND_DELIVER;
                seq_next  = next_exp_reg;
                ref_next  = slot_ref_reg[0];
                len_next  = slot_len_reg[0];
            end
            srr_pkg::SRC_REJECT:
            begin
                kind_next = srr_pkg::KIND_REJECT;
            end
            default:
            begin
                kind_next = srr_pkg::KIND_ACK;
            end
        endcase
        sum_next   = {1'b0, delivered_reg} + (BYTES_W + 1)'(len_next);
        bytes_next = sum_next[BYTES_W] ? '1 : sum_next[BYTES_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_total_reg <= '0;
            delivered_reg      <= '0;
            next_exp_reg       <= SEQ_BITS'(1);
            slot_full_reg      <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                expected_total_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                delivered_reg <= bytes_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.advance)
            begin
                next_exp_reg  <= next_exp_reg + SEQ_BITS'(1);
                slot_full_reg <= full_ext[WINDOW_SLOTS:1];
            end
            else if (store_en)
            begin
                slot_full_reg[off_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seq_reg <= seq_in;
            off_reg <= seq_in - next_exp_reg;
            ref_reg <= payload_ref;
            len_reg <= len_clamped;
        end
        if (cmd.advance)
        begin
            for (int i = 0; i + 1 < WINDOW_SLOTS; i++)
            begin
                slot_ref_reg[i] <= slot_ref_reg[i + 1];
                slot_len_reg[i] <= slot_len_reg[i + 1];
            end
        end
        else if (store_en)
        begin
            slot_ref_reg[off_idx] <= ref_reg;
            slot_len_reg[off_idx] <= len_reg;
        end
        if (cmd.emit)
        begin
            kind_reg    <= kind_next;
            out_seq_reg <= seq_next;
            out_ref_reg <= ref_next;
            out_len_reg <= len_next;
            bytes_reg   <= bytes_next;
            done_reg    <= (bytes_next >= expected_total_reg);
            last_reg    <= cmd.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign out_seq       = srr_pkg::SEQ_W'(out_seq_reg);
    assign out_ref       = out_ref_reg;
    assign out_len       = out_len_reg;
    assign bytes_so_far  = bytes_reg;
    assign transfer_done = done_reg;
    assign last          = last_reg;

    // Buffering only targets a slot strictly ahead of the expected number.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (off_reg != '0) && status.in_win)
        else $error("store outside the buffered part of the window");

    // Draining only reads the head slot when it actually holds a packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.src == srr_pkg::SRC_SLOT_DELIVER) |-> slot_full_reg[0])
        else $error("drain from an empty head slot");

    // The delivered byte count never goes backward.
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (delivered_reg >= $past(delivered_reg)))
        else $error("delivered byte count decreased");

endmodule

// File: rtl/selective_repeat_receiver_top.sv
// An accepted item is held in the current-packet register; its first result goes to the
// output register once that is free. Out-of-order, behind-window and rejected items give
// one result each, the expected item a delivery, an ack and one delivery per released
// buffered item; the single output register takes one result per cycle while it is free.
// Reset (rst_n, asynchronous, active low) clears the window, byte count and size register.
module selective_repeat_receiver_top #(
    parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEF,
    parameter int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF,
    parameter int MAX_PAYLOAD  = srr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: the announced transfer size in bytes.
    input  logic                          cfg_we,
    input  logic [srr_pkg::BYTES_W-1:0]   cfg_data,
    // Input channel: one data packet per item.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [srr_pkg::SEQ_W-1:0]     packet_seq,
    input  logic [srr_pkg::REF_W-1:0]     payload_ref,
    input  logic [srr_pkg::LEN_W-1:0]     payload_len,
    // Output channel: acknowledgements, deliveries and rejections.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [srr_pkg::KIND_W-1:0]    kind,
    output logic [srr_pkg::SEQ_W-1:0]     out_seq,
    output logic [srr_pkg::REF_W-1:0]     out_ref,
    output logic [srr_pkg::LEN_W-1:0]     out_len,
    output logic [srr_pkg::BYTES_W-1:0]   bytes_so_far,
    output logic                          transfer_done,
    output logic                          last
);

    // The controller sequences each item: it captures the packet, then emits
    // one result per cycle whenever the output register is free. For the
    // expected packet it emits the delivery, the acknowledgement (advancing
    // the window), and then drains contiguous buffered packets from the head
    // slot, one per cycle, until the next slot is empty.
    srr_pkg::cmd_t    cmd;
    srr_pkg::status_t status;

    srr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the window as a shift line of slots, the running
    // byte total with saturation, and the output register. An accepted item
    // is held in its own register, so the next item can be taken while the
    // last result of the previous one still waits at the output.
    srr_dp #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .SEQ_BITS     (SEQ_BITS),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .packet_seq    (packet_seq),
        .payload_ref   (payload_ref),
        .payload_len   (payload_len),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .out_seq       (out_seq),
        .out_ref       (out_ref),
        .out_len       (out_len),
        .bytes_so_far  (bytes_so_far),
        .transfer_done (transfer_done),
        .last          (last)
    );

endmodule

// File: verif/selective_repeat_receiver_checker.sv
module selective_repeat_receiver_checker #(
    parameter int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEF,
    parameter int MAX_PAYLOAD  = srr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [srr_pkg::BYTES_W-1:0] cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [srr_pkg::SEQ_W-1:0]   packet_seq,
    input  logic [srr_pkg::REF_W-1:0]   payload_ref,
    input  logic [srr_pkg::LEN_W-1:0]   payload_len,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [srr_pkg::KIND_W-1:0]  kind,
    input  logic [srr_pkg::SEQ_W-1:0]   out_seq,
    input  logic [srr_pkg::REF_W-1:0]   out_ref,
    input  logic [srr_pkg::LEN_W-1:0]   out_len,
    input  logic [srr_pkg::BYTES_W-1:0] bytes_so_far,
    input  logic                        transfer_done,
    input  logic                        last,
    output int                          fail_count,
    output int                          results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 40;
    localparam int SEQ_W       = srr_pkg::SEQ_W;
    localparam int REF_W       = srr_pkg::REF_W;
    localparam int LEN_W       = srr_pkg::LEN_W;
    localparam int BYTES_W     = srr_pkg::BYTES_W;

    typedef struct {
        srr_pkg::kind_t     kind;
        logic [SEQ_W-1:0]   seq;
        logic [REF_W-1:0]   pay_ref;
        logic [LEN_W-1:0]   len;
        logic [BYTES_W-1:0] bytes;
        logic               done;
        logic               last;
    } rx_result_t;

    rx_result_t         expected_results[$];

    // Shadow of the receive window and the byte counter.
    logic [SEQ_W-1:0]   next_seq;
    logic               slot_full [WINDOW_SLOTS];
    logic [REF_W-1:0]   slot_ref  [WINDOW_SLOTS];
    logic [LEN_W-1:0]   slot_len  [WINDOW_SLOTS];
    logic [BYTES_W-1:0] delivered;
    logic [BYTES_W-1:0] total_bytes;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < MAX_PRINTED)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic push_result(input srr_pkg::kind_t k, input logic [SEQ_W-1:0] seq,
                               input logic [REF_W-1:0] pay_ref,
                               input logic [LEN_W-1:0] len);
        rx_result_t r;
        r.kind    = k;
        r.seq     = seq;
        r.pay_ref = pay_ref;
        r.len     = len;
        r.bytes   = delivered;
        r.done    = (delivered >= total_bytes);
        r.last    = 1'b0;
        expected_results.push_back(r);
    endtask

    task automatic credit_bytes(input logic [LEN_W-1:0] len);
        logic [BYTES_W:0] sum;
        sum = {1'b0, delivered} + (BYTES_W + 1)'(len);
        delivered = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
    endtask

    task automatic shift_window();
        for (int i = 0; i + 1 < WINDOW_SLOTS; i++)
        begin
            slot_full[i] = slot_full[i + 1];
            slot_ref[i]  = slot_ref[i + 1];
            slot_len[i]  = slot_len[i + 1];
        end
        slot_full[WINDOW_SLOTS - 1] = 1'b0;
        next_seq = next_seq + SEQ_W'(1);
    endtask

    task automatic predict_packet(input logic [SEQ_W-1:0] seq,
                                  input logic [REF_W-1:0] pay_ref,
                                  input logic [LEN_W-1:0] raw_len);
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] off;
        rx_result_t       tail;
        len = (raw_len > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : raw_len;
        off = seq - next_seq;
        if (off == 0)
        begin
            credit_bytes(len);
            push_result(srr_pkg::KIND_DELIVER, seq, pay_ref, len);
            push_result(srr_pkg::KIND_ACK, seq, '0, '0);
            shift_window();
            while (slot_full[0])
            begin
                credit_bytes(slot_len[0]);
                push_result(srr_pkg::KIND_DELIVER, next_seq, slot_ref[0], slot_len[0]);
                shift_window();
            end
        end
        else if (32'(off) < WINDOW_SLOTS)
        begin
            if (!slot_full[off])
            begin
                slot_full[off] = 1'b1;
                slot_ref[off]  = pay_ref;
                slot_len[off]  = len;
            end
            push_result(srr_pkg::KIND_ACK, seq, '0, '0);
        end
        else if (32'(off) >= (2 ** SEQ_W) - WINDOW_SLOTS)
            push_result(srr_pkg::KIND_ACK, seq, '0, '0);
        else
            push_result(srr_pkg::KIND_REJECT, seq, '0, '0);
        tail = expected_results.pop_back();
        tail.last = 1'b1;
        expected_results.push_back(tail);
    endtask

    task automatic check_result();
        rx_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing expected, seq", out_seq, 0);
            return;
        end
        want = expected_results.pop_front();
        if (srr_pkg::kind_t'(kind) !== want.kind)
            report_mismatch("kind", kind, want.kind);
        if (out_seq !== want.seq)
            report_mismatch("out_seq", out_seq, want.seq);
        if (out_ref !== want.pay_ref)
            report_mismatch("out_ref", out_ref, want.pay_ref);
        if (out_len !== want.len)
            report_mismatch("out_len", out_len, want.len);
        if (bytes_so_far !== want.bytes)
            report_mismatch("bytes_so_far", bytes_so_far, want.bytes);
        if (transfer_done !== want.done)
            report_mismatch("transfer_done", transfer_done, want.done);
        if (last !== want.last)
            report_mismatch("last", last, want.last);
    endtask

    // Results are checked before the same edge's input is predicted; a new item
    // cannot produce a result in the cycle it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count  = 0;
            next_seq    = SEQ_W'(1);
            delivered   = '0;
            total_bytes = '0;
            for (int i = 0; i < WINDOW_SLOTS; i++)
                slot_full[i] = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_we)
                total_bytes = cfg_data;
            if (in_valid && !in_stall)
                predict_packet(packet_seq, payload_ref, payload_len);
        end
        results_pending = expected_results.size();
    end

endmodule

// File: verif/selective_repeat_receiver_top_tb.sv
module selective_repeat_receiver_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_SLOTS = srr_pkg::WINDOW_SLOTS_DEF;
    localparam int MAX_PAYLOAD  = srr_pkg::MAX_PAYLOAD_DEF;
    localparam int SEQ_BITS     = srr_pkg::SEQ_BITS_DEF;
    localparam int SEQ_W        = srr_pkg::SEQ_W;
    localparam int REF_W        = srr_pkg::REF_W;
    localparam int LEN_W        = srr_pkg::LEN_W;
    localparam int KIND_W       = srr_pkg::KIND_W;
    localparam int BYTES_W      = srr_pkg::BYTES_W;

    // The longest legal quiet stretch is the deliberate receiver hold-off, so
    // the watchdog limit sits well above it.
    localparam int SQUEEZE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    // A result goes from the current-packet register to the output register once
    // that is free, so the drain wait covers anything still moving inside the block.
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 75;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [BYTES_W-1:0] cfg_data      = '0;
    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [SEQ_W-1:0]   packet_seq    = '0;
    logic [REF_W-1:0]   payload_ref   = '0;
    logic [LEN_W-1:0]   payload_len   = '0;
    logic               out_valid;
    logic               out_stall     = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [SEQ_W-1:0]   out_seq;
    logic [REF_W-1:0]   out_ref;
    logic [LEN_W-1:0]   out_len;
    logic [BYTES_W-1:0] bytes_so_far;
    logic               transfer_done;
    logic               last;

    int                 fail_count;
    int                 results_pending;

    // Handshake between the stimulus and the receiver process: the stimulus
    // asks once for a long hold-off, the receiver carries it out by itself.
    logic               squeeze_req   = 1'b0;
    // While set, the sender offers items back to back without gaps.
    logic               sender_quiet  = 1'b0;
    // The sequence number the stimulus believes the block expects next.
    logic [SEQ_W-1:0]   stim_next;
    int                 idle_cycles;

    selective_repeat_receiver_top #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .SEQ_BITS     (SEQ_BITS),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .packet_seq    (packet_seq),
        .payload_ref   (payload_ref),
        .payload_len   (payload_len),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .out_seq       (out_seq),
        .out_ref       (out_ref),
        .out_len       (out_len),
        .bytes_so_far  (bytes_so_far),
        .transfer_done (transfer_done),
        .last          (last)
    );

    // The checker watches both channels and the register port on its own and
    // keeps the running count of mismatches and of outstanding results.
    selective_repeat_receiver_checker #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .packet_seq      (packet_seq),
        .payload_ref     (payload_ref),
        .payload_len     (payload_len),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .out_seq         (out_seq),
        .out_ref         (out_ref),
        .out_len         (out_len),
        .bytes_so_far    (bytes_so_far),
        .transfer_done   (transfer_done),
        .last            (last),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // 2 ns clock, rising edges at odd nanoseconds.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Payload lengths: mostly legal, some at the extremes, some overlong so
    // that the clamp to the maximum payload is exercised.
    function automatic logic [LEN_W-1:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return LEN_W'($urandom_range(MAX_PAYLOAD + 1, (1 << LEN_W) - 1));
        else if (r < 12)
            return ($urandom_range(0, 1) != 0) ? LEN_W'(MAX_PAYLOAD) : '0;
        else
            return LEN_W'($urandom_range(1, MAX_PAYLOAD));
    endfunction

    // Offers one item at a falling edge and holds it until the block takes it.
    // After acceptance valid is dropped only when a gap follows, so a back to
    // back item never sees valid lowered and raised in the same time step.
    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [REF_W-1:0] pay_ref,
                               input logic [LEN_W-1:0] len);
        int gap;
        @(negedge clk);
        in_valid    <= 1'b1;
        packet_seq  <= seq;
        payload_ref <= pay_ref;
        payload_len <= len;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        gap = sender_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Waits until every predicted result has come out and the block has had
    // time to finish whatever it may still be doing.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // The size register is only rewritten while the block is idle.
    task automatic write_total(input logic [BYTES_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random phase. Most of the traffic is runs of up to a window of consecutive
    // packets, mostly sent in shuffled order, with the odd duplicate thrown in, so the
    // block keeps buffering and releasing runs. Between runs the noise is
    // packets just behind the window, just past it, or anywhere far off.
    task automatic run_phase(input int items);
        int               sent;
        int               k;
        int               j;
        int               t;
        int               order [WINDOW_SLOTS];
        logic [SEQ_W-1:0] seq;
        sent = 0;
        while (sent < items)
        begin
            sender_quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 80)
            begin
                k = $urandom_range(1, WINDOW_SLOTS);
                for (int i = 0; i < k; i++)
                    order[i] = i;
                if ($urandom_range(0, 3) != 0)
                begin
                    for (int i = k - 1; i > 0; i--)
                    begin
                        j = $urandom_range(0, i);
                        t = order[i];
                        order[i] = order[j];
                        order[j] = t;
                    end
                end
                for (int i = 0; i < k; i++)
                begin
                    send_packet(stim_next + SEQ_W'(order[i]), $urandom(), rand_len());
                    sent++;
                    // A repeat of a packet already sent is either still buffered
                    // or already delivered; neither moves the window.
                    if ($urandom_range(0, 9) == 0)
                    begin
                        j = $urandom_range(0, i);
                        send_packet(stim_next + SEQ_W'(order[j]), $urandom(), rand_len());
                        sent++;
                    end
                end
                stim_next = stim_next + SEQ_W'(k);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: seq = stim_next - SEQ_W'($urandom_range(1, WINDOW_SLOTS));
                    1: seq = stim_next + SEQ_W'(WINDOW_SLOTS + $urandom_range(0, 3));
                    default:
                    begin
                        seq = SEQ_W'($urandom());
                        // Keep far-off noise out of the window so the stimulus
                        // still knows where the window stands.
                        if (SEQ_W'(seq - stim_next) < SEQ_W'(2 * WINDOW_SLOTS))
                            seq = seq ^ {1'b1, {(SEQ_W - 1){1'b0}}};
                    end
                endcase
                send_packet(seq, $urandom(), rand_len());
                sent++;
            end
        end
        sender_quiet = 1'b0;
    endtask

    // Receiver: random stalls of mixed length alternating with runs of free
    // flow, some of them long. Once the stimulus asks for it, the receiver
    // holds off for a long stretch while the sender keeps offering items, so
    // the output backs up and the block has to stall its input.
    initial
    begin : receiver
        int stall_len;
        int run_len;
        logic squeeze_done;
        squeeze_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (squeeze_req && !squeeze_done)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                squeeze_done = 1'b1;
            end
            else
            begin
                stall_len = pick_gap();
                if (stall_len > 0)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat (stall_len - 1) @(negedge clk);
                end
                run_len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
                @(negedge clk);
                out_stall <= 1'b0;
                repeat (run_len - 1) @(negedge clk);
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [BYTES_W-1:0] phase_total [4];

        // Reset is held from time zero and released on a falling edge.
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The window starts at sequence number one. The size is
        // chosen so the byte count crosses it partway through.
        write_total(BYTES_W'(12000));
        send_packet(16'd1, '1, LEN_W'(MAX_PAYLOAD));   // expected packet, delivered at once
        send_packet(16'd3, '0, '0);                    // next slot up, buffered
        send_packet(16'd3, 32'h5A5A_A5A5, 11'd5);     // duplicate of a buffered packet
        send_packet(16'd9, 32'h1234_5678, '1);         // top of the window, overlong length
        send_packet(16'd10, '1, 11'd100);              // first number past the window
        send_packet(16'd0, 32'hDEAD_BEEF, 11'd7);      // just behind the window
        send_packet(16'hFFFA, 32'h0F0F_0F0F, 11'd8);  // deepest point still behind
        send_packet(16'hFFF9, 32'hF0F0_F0F0, 11'd9);  // one past that, rejected
        send_packet(16'd2, 32'h8000_0001, 11'd1025);   // releases the buffered three
        for (int s = 8; s >= 5; s--)
            send_packet(SEQ_W'(s), $urandom(), LEN_W'(MAX_PAYLOAD));
        send_packet(16'd4, $urandom(), LEN_W'(MAX_PAYLOAD));  // releases five to nine
        // Fill every slot ahead of the expected number, then release all of them
        // at once for the longest burst of results one item can cause.
        for (int s = 11; s <= 17; s++)
            send_packet(SEQ_W'(s), $urandom(), LEN_W'(MAX_PAYLOAD));
        send_packet(16'd10, $urandom(), LEN_W'(MAX_PAYLOAD));
        stim_next = 16'd18;

        // Random part: four settings of the size register, the extremes first.
        phase_total[0] = '0;
        phase_total[1] = '1;
        phase_total[2] = BYTES_W'($urandom_range(100000, 300000));
        phase_total[3] = BYTES_W'($urandom());
        for (int p = 0; p < 4; p++)
        begin
            write_total(phase_total[p]);
            if (p == 1)
                squeeze_req = 1'b1;
            run_phase(PHASE_ITEMS);
        end

        settle();
        if (fail_count == 0 && results_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/srr_pkg.sv
rtl/srr_ctrl.sv
rtl/srr_dp.sv
rtl/selective_repeat_receiver_top.sv
verif/selective_repeat_receiver_checker.sv
verif/selective_repeat_receiver_top_tb.sv
